[hdl/ttlc_pkg.sv]
// Package: shared constants, state encodings and status types for the tap tempo chaser.
package ttlc_pkg;

    localparam int MAX_STEPS = 8;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int CNT_W     = 16;
    localparam int KEY_W     = 6;
    localparam int CH_W      = 4;
    localparam int PAT_W     = CH_W * MAX_STEPS;
    localparam int LEN_W     = 4;

    localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd500;
    localparam logic [CNT_W-1:0] PULSE_RESET  = 16'd50;
    localparam logic [PAT_W-1:0] PATTERN_RESET = 32'h0000_8421;
    localparam logic [LEN_W-1:0] STEPS_RESET  = 4'd4;

    // Key bit positions.
    localparam int KEY_CH2 = 0;
    localparam int KEY_CH4 = 1;
    localparam int KEY_RUN = 2;
    localparam int KEY_CH1 = 3;
    localparam int KEY_CH3 = 4;
    localparam int KEY_TAP = 5;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PATTERN = 2'd0,
        CFG_STEPS   = 2'd1,
        CFG_PULSE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BEAT_START = 2'd0,
        BEAT_LIT   = 2'd1,
        BEAT_DARK  = 2'd2
    } t_beat_phase;

    typedef enum logic [1:0] {
        RUN_STOP  = 2'd0,
        RUN_START = 2'd1,
        RUN_STEP  = 2'd2
    } t_run_phase;

    // Heartbeat status handed to the sequencer.
    typedef struct packed {
        logic start;
        logic led;
    } t_beat_st;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

[hdl/tap_tempo_led_chaser.sv]
// Top level: tap tempo LED chaser with input register, tick logic and result register.
// A beat passes through the input register and then the result register before it shows.
// Throughput: one tick per cycle; the input register advances whenever the result
// register is empty or being drained; a stalled result holds intake once both are full.
// Reset (synchronous, active low): pipeline empty, config back to its defaults,
// beat period 500, run machine in cycle start, step 0, heartbeat at beat start.
module tap_tempo_led_chaser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ttlc_pkg::KEY_W-1:0]  i_keys,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ttlc_pkg::CH_W-1:0]   o_channels,
    output logic                        o_beat_led,
    output logic                        o_running,
    output logic [ttlc_pkg::STEP_W-1:0] o_current_step,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [ttlc_pkg::PAT_W-1:0]  i_cfg_data
);
    import ttlc_pkg::*;

    // Configuration registers.
    logic [PAT_W-1:0]  r_pattern;
    logic [LEN_W-1:0]  r_step_count;
    logic [CNT_W-1:0]  r_pulse_ticks;

    // Input stage.
    logic              r_in_valid;
    logic [KEY_W-1:0]  r_in_keys;

    // Edge detect history, updated as each tick is processed.
    logic [KEY_W-1:0]  r_prev_keys;
    logic [KEY_W-1:0]  w_rise;

    // Result stage.
    logic              r_out_valid;
    logic [CH_W-1:0]   r_channels;
    logic              r_beat_led;
    logic              r_running;
    logic [STEP_W-1:0] r_step;

    logic              w_move;
    t_beat_st          w_beat;
    logic [CH_W-1:0]   w_channels;
    logic              w_running;
    logic [STEP_W-1:0] w_step;

    // Advance a tick from the input register when the result register frees up.
    assign w_move      = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;
    assign w_rise      = r_in_keys & ~r_prev_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= PATTERN_RESET;
            r_step_count  <= STEPS_RESET;
            r_pulse_ticks <= PULSE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN: r_pattern     <= i_cfg_data;
                CFG_STEPS:   r_step_count  <= i_cfg_data[LEN_W-1:0];
                CFG_PULSE:   r_pulse_ticks <= i_cfg_data[CNT_W-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Input register: hold the beat until the tick logic takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_keys <= i_keys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= '0;
        end else if (w_move) begin
            r_prev_keys <= r_in_keys;
        end
    end

    ttlc_beat u_beat (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_move),
        .i_tap_rise    (w_rise[KEY_TAP]),
        .i_pulse_ticks (r_pulse_ticks),
        .o_status      (w_beat)
    );

    ttlc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_move),
        .i_run_rise   (w_rise[KEY_RUN]),
        .i_keys       (r_in_keys),
        .i_beat       (w_beat),
        .i_pattern    (r_pattern),
        .i_step_count (r_step_count),
        .o_channels   (w_channels),
        .o_running    (w_running),
        .o_step       (w_step)
    );

    // Result register: load on each processed tick, clear on drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_channels <= w_channels;
            r_beat_led <= w_beat.led;
            r_running  <= w_running;
            r_step     <= w_step;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_channels     = r_channels;
    assign o_beat_led     = r_beat_led;
    assign o_running      = r_running;
    assign o_current_step = r_step;

endmodule

[hdl/ttlc_beat.sv]
// Tap tempo measurement and heartbeat phase machine.
module ttlc_beat (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_tap_rise,
    input  logic [ttlc_pkg::CNT_W-1:0] i_pulse_ticks,
    output ttlc_pkg::t_beat_st         o_status
);
    import ttlc_pkg::*;

    logic              r_tap_armed, n_tap_armed;
    logic [CNT_W-1:0]  r_tap_elapsed, n_tap_elapsed;
    logic [CNT_W-1:0]  r_period, n_period;
    logic [CNT_W-1:0]  r_elapsed, n_elapsed;
    logic [CNT_W-1:0]  w_inc;
    logic              w_tap_done;
    t_beat_phase       r_phase, n_phase, w_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_armed   <= 1'b0;
            r_tap_elapsed <= '0;
            r_period      <= PERIOD_RESET;
            r_elapsed     <= '0;
            r_phase       <= BEAT_START;
        end else if (i_en) begin
            r_tap_armed   <= n_tap_armed;
            r_tap_elapsed <= n_tap_elapsed;
            r_period      <= n_period;
            r_elapsed     <= n_elapsed;
            r_phase       <= n_phase;
        end
    end

    always_comb begin
        n_tap_armed   = r_tap_armed;
        n_tap_elapsed = r_tap_elapsed;
        n_period      = r_period;
        w_tap_done    = 1'b0;
        if (r_tap_armed) begin
            n_tap_elapsed = sat_inc(r_tap_elapsed);
            if (i_tap_rise) begin
                n_tap_armed = 1'b0;
                n_period    = n_tap_elapsed;
                w_tap_done  = 1'b1;
            end
        end else if (i_tap_rise) begin
            n_tap_armed   = 1'b1;
            n_tap_elapsed = '0;
        end

        // A finished measurement restarts the beat in the same tick.
        w_phase   = w_tap_done ? BEAT_START : r_phase;
        w_inc     = sat_inc(r_elapsed);
        n_elapsed = r_elapsed;
        n_phase   = w_phase;
        unique case (w_phase)
            BEAT_START: begin
                n_phase   = BEAT_LIT;
                n_elapsed = '0;
            end
            BEAT_LIT: begin
                n_elapsed = w_inc;
                if (w_inc >= i_pulse_ticks) n_phase = BEAT_DARK;
            end
            BEAT_DARK: begin
                n_elapsed = w_inc;
                if (w_inc >= n_period) n_phase = BEAT_START;
            end
            default: n_phase = BEAT_START;
        endcase

        o_status.start = (w_phase == BEAT_START);
        o_status.led   = (n_phase == BEAT_LIT);
    end

endmodule

[hdl/ttlc_seq.sv]
// Run machine, step index and channel drive.
module ttlc_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_run_rise,
    input  logic [ttlc_pkg::KEY_W-1:0]  i_keys,
    input  ttlc_pkg::t_beat_st          i_beat,
    input  logic [ttlc_pkg::PAT_W-1:0]  i_pattern,
    input  logic [ttlc_pkg::LEN_W-1:0]  i_step_count,
    output logic [ttlc_pkg::CH_W-1:0]   o_channels,
    output logic                        o_running,
    output logic [ttlc_pkg::STEP_W-1:0] o_step
);
    import ttlc_pkg::*;

    t_run_phase        r_phase, n_phase;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_advance, n_advance;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_next;
    logic              w_used;
    logic [CH_W-1:0]   w_nib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= RUN_START;
            r_step    <= '0;
            r_advance <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_advance <= n_advance;
        end
    end

    always_comb begin
        // Clamp the step count to 1..MAX_STEPS.
        if (i_step_count == '0)
            w_len = LEN_W'(1);
        else if (i_step_count > LEN_W'(MAX_STEPS))
            w_len = LEN_W'(MAX_STEPS);
        else
            w_len = i_step_count;

        w_next  = LEN_W'(r_step) + 1'b1;
        n_phase = r_phase;
        n_step  = r_step;
        w_used  = 1'b0;
        unique case (r_phase)
            RUN_STOP:  if (i_run_rise) n_phase = RUN_START;
            RUN_START: n_phase = i_run_rise ? RUN_STOP : RUN_STEP;
            RUN_STEP: begin
                if (i_run_rise) begin
                    n_phase = RUN_STOP;
                end else if (r_advance) begin
                    n_step  = (w_next >= w_len) ? '0 : w_next[STEP_W-1:0];
                    n_phase = RUN_START;
                    w_used  = 1'b1;
                end
            end
            default: n_phase = RUN_STOP;
        endcase

        // Beat start wins over consumption of the flag.
        n_advance = i_beat.start | (r_advance & ~w_used);

        w_nib      = i_pattern[n_step*CH_W +: CH_W];
        o_channels = w_nib | {i_keys[KEY_CH4], i_keys[KEY_CH3],
                              i_keys[KEY_CH2], i_keys[KEY_CH1]};
        o_running  = (n_phase == RUN_START) || (n_phase == RUN_STEP);
        o_step     = n_step;
    end

endmodule

[hdl/ttlc_checker.sv]
// Port-level checker for the tap tempo chaser, bound to the top level.
module ttlc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [ttlc_pkg::CH_W-1:0]   o_channels,
    input logic                        o_beat_led,
    input logic                        o_running,
    input logic [ttlc_pkg::STEP_W-1:0] o_current_step
);

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An empty result register never blocks intake.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("intake stalled with empty result register");

    // A stalled result keeps its valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_channels) && $stable(o_beat_led)
                                && $stable(o_running) && $stable(o_current_step))
        else $error("result payload changed while stalled");

endmodule

bind tap_tempo_led_chaser ttlc_checker u_ttlc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_channels     (o_channels),
    .o_beat_led     (o_beat_led),
    .o_running      (o_running),
    .o_current_step (o_current_step)
);

[dv/tap_tempo_led_chaser_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the tap tempo chaser: directed table, then random key sequences.
module tap_tempo_led_chaser_tb;

    import ttlc_pkg::*;

    localparam int CLK_PERIOD_NS  = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int DUT_LAT        = 2;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int MAX_SHOWN      = 10;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_TICKS    = 160;
    localparam int GAP_TICKS      = 24;

    // Index 3 has no register behind it; writes there must leave the block alone.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam logic [KEY_W-1:0] TAP_KEY = KEY_W'(1) << KEY_TAP;

    typedef struct packed {
        logic [CH_W-1:0]   channels;
        logic              beat_led;
        logic              running;
        logic [STEP_W-1:0] step;
    } t_chaser_out;

    typedef enum logic {
        ROW_TICK  = 1'b0,
        ROW_SETUP = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [KEY_W-1:0]  keys;
        logic [PAT_W-1:0]  pat;
        logic [LEN_W-1:0]  steps;
        logic [CNT_W-1:0]  pulse;
        logic              typed;
        t_chaser_out       want;
    } t_dir_row;

    localparam int NUM_ROWS = 32;

    // Directed table. Only the first two ticks after reset carry a typed result;
    // every other row is checked against the predictor.
    t_dir_row directed_rows [NUM_ROWS] = '{
        // first tick out of reset: step 0 of the default pattern, LED lit, running
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b1, '{4'h1, 1'b1, 1'b1, 3'd0}},
        // advance flag from the first beat moves to step 1
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b1, '{4'h2, 1'b1, 1'b1, 3'd1}},
        // every key rises at once, then hold them all
        '{ROW_TICK,  6'h3F, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h3F, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // second tap closes a short measurement and restarts the beat
        '{ROW_TICK,  6'h20, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // restart the sequence
        '{ROW_TICK,  6'h04, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // walk each held channel key alone
        '{ROW_TICK,  6'h01, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h02, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h08, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h10, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // zero step count and zero pulse length
        '{ROW_SETUP, 6'h00, 32'hFFFF_FFFF, 4'h0, 16'h0000, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // step count above the table size, longest pulse, empty pattern
        '{ROW_SETUP, 6'h00, 32'h0000_0000, 4'hF, 16'hFFFF, 1'b0, '0},
        '{ROW_TICK,  6'h1B, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // full table, one-tick pulse, tap in a two-tick beat
        '{ROW_SETUP, 6'h00, 32'h7654_3210, 4'h8, 16'h0001, 1'b0, '0},
        '{ROW_TICK,  6'h20, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h20, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        // shrink the step count under the current index: show it, then wrap
        '{ROW_SETUP, 6'h00, 32'hFEDC_BA98, 4'h2, 16'h0001, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0},
        '{ROW_TICK,  6'h00, 32'h0, 4'h0, 16'h0, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [KEY_W-1:0]      i_keys;
    logic                  o_valid;
    logic                  i_ready;
    logic [CH_W-1:0]       o_channels;
    logic                  o_beat_led;
    logic                  o_running;
    logic [STEP_W-1:0]     o_current_step;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [PAT_W-1:0]      i_cfg_data;

    // Shadow copy of the configuration registers.
    logic [PAT_W-1:0]      pat_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CNT_W-1:0]      pulse_reg;

    // Predictor state.
    logic [KEY_W-1:0]      seen_keys;
    logic                  tap_open;
    logic [CNT_W-1:0]      tap_count;
    logic [CNT_W-1:0]      period_q;
    t_beat_phase           beat_st;
    logic [CNT_W-1:0]      beat_count;
    logic                  step_due;
    t_run_phase            seq_st;
    logic [STEP_W-1:0]     step_q;

    t_chaser_out           expected_lamps [$];
    int                    fails   = 0;
    bit                    idle_on = 1'b1;

    tap_tempo_led_chaser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_keys         (i_keys),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channels     (o_channels),
        .o_beat_led     (o_beat_led),
        .o_running      (o_running),
        .o_current_step (o_current_step),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
        $display("FAIL");
        $finish;
    end

    function automatic logic [CNT_W-1:0] sat16(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Advance the predictor by one tick and return the lamp state it shows.
    // Order matters: tap tempo, then the run machine, then the heartbeat.
    function automatic t_chaser_out predict_tick(input logic [KEY_W-1:0] keys);
        logic [KEY_W-1:0]  rise;
        logic [LEN_W-1:0]  len;
        logic [STEP_W:0]   nxt;
        t_chaser_out       r;
        rise      = keys & ~seen_keys;
        seen_keys = keys;

        // A completed measurement restarts the heartbeat in this same tick.
        if (tap_open) begin
            tap_count = sat16(tap_count);
            if (rise[KEY_TAP]) begin
                tap_open = 1'b0;
                period_q = tap_count;
                beat_st  = BEAT_START;
            end
        end else if (rise[KEY_TAP]) begin
            tap_open  = 1'b1;
            tap_count = '0;
        end

        // Zero acts as one step; anything past the table clamps to its size.
        if (len_reg == '0)
            len = LEN_W'(1);
        else if (len_reg > MAX_STEPS)
            len = LEN_W'(MAX_STEPS);
        else
            len = len_reg;

        case (seq_st)
            RUN_STOP: begin
                if (rise[KEY_RUN]) seq_st = RUN_START;
            end
            RUN_START: begin
                seq_st = rise[KEY_RUN] ? RUN_STOP : RUN_STEP;
            end
            RUN_STEP: begin
                if (rise[KEY_RUN]) begin
                    seq_st = RUN_STOP;
                end else if (step_due) begin
                    nxt      = step_q + 1'b1;
                    step_q   = (nxt >= len) ? '0 : nxt[STEP_W-1:0];
                    seq_st   = RUN_START;
                    step_due = 1'b0;
                end
            end
            default: seq_st = RUN_STOP;
        endcase

        case (beat_st)
            BEAT_START: begin
                beat_st    = BEAT_LIT;
                beat_count = '0;
                step_due   = 1'b1;
            end
            BEAT_LIT: begin
                beat_count = sat16(beat_count);
                if (beat_count >= pulse_reg) beat_st = BEAT_DARK;
            end
            BEAT_DARK: begin
                beat_count = sat16(beat_count);
                if (beat_count >= period_q) beat_st = BEAT_START;
            end
            default: beat_st = BEAT_START;
        endcase

        r.channels = pat_reg[step_q * CH_W +: CH_W]
                   | {keys[KEY_CH4], keys[KEY_CH3], keys[KEY_CH2], keys[KEY_CH1]};
        r.beat_led = (beat_st == BEAT_LIT);
        r.running  = (seq_st == RUN_START) || (seq_st == RUN_STEP);
        r.step     = step_q;
        return r;
    endfunction

    task automatic flag_bad(input string why, input t_chaser_out want, input t_chaser_out got);
        fails++;
        if (fails <= MAX_SHOWN)
            $display("%0t %s: exp ch=%h led=%b run=%b step=%0d, %s%h led=%b run=%b step=%0d",
                     $time, why, want.channels, want.beat_led, want.running, want.step,
                     "got ch=", got.channels, got.beat_led, got.running, got.step);
    endtask

    // Present one tick beat, hold it until accepted, then queue its expected lamps.
    // A typed row overrides the prediction, but the predictor still steps.
    task automatic push_tick(input logic [KEY_W-1:0] keys, input logic typed,
                             input t_chaser_out want);
        int          gap;
        t_chaser_out guess;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 7);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_keys  = keys;
        do @(posedge i_clk); while (!o_ready);
        guess = predict_tick(keys);
        expected_lamps.push_back(typed ? want : guess);
        @(negedge i_clk);
    endtask

    // Write one register beat; the shadow copy follows at the accepting edge.
    task automatic cfg_write(input logic [1:0] idx, input logic [PAT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PATTERN: pat_reg   = data;
            CFG_STEPS:   len_reg   = data[LEN_W-1:0];
            CFG_PULSE:   pulse_reg = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Load all three registers, with junk in the unused upper data bits,
    // and poke the spare index as well.
    task automatic apply_setup(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] steps,
                               input logic [CNT_W-1:0] pulse);
        logic [PAT_W-1:0] fill;
        fill = $urandom;
        cfg_write(CFG_PATTERN, pat);
        cfg_write(CFG_STEPS, {fill[PAT_W-1:LEN_W], steps});
        cfg_write(CFG_PULSE, {fill[PAT_W-1:CNT_W], pulse});
        cfg_write(CFG_SPARE, ~pat);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid, wait out every pending result, then let the pipe settle.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (expected_lamps.size() != 0) @(negedge i_clk);
        repeat (DUT_LAT + 2) @(negedge i_clk);
    endtask

    // Result side: stall in random bursts while idling is on, otherwise always ready.
    initial begin : result_sink
        int stall;
        stall   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall == 0 && idle_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 7);
            i_ready = (stall == 0);
            if (stall > 0) stall--;
        end
    end

    // Compare every result beat against the oldest pending expectation.
    always @(posedge i_clk) begin : result_check
        t_chaser_out got;
        t_chaser_out want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_channels, o_beat_led, o_running, o_current_step};
            if (expected_lamps.size() == 0) begin
                flag_bad("result with nothing pending", '0, got);
            end else begin
                want = expected_lamps.pop_front();
                if (got.channels !== want.channels || got.beat_led !== want.beat_led ||
                    got.running !== want.running || got.step !== want.step)
                    flag_bad("result mismatch", want, got);
            end
        end
    end

    initial begin : stimulus
        int               n;
        int               ph;
        int               k;
        int               tap_wait;
        int               pick;
        logic [KEY_W-1:0] lvl;
        logic [KEY_W-1:0] keys;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] steps;
        logic [CNT_W-1:0] pulse;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_keys      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        pat_reg    = PATTERN_RESET;
        len_reg    = STEPS_RESET;
        pulse_reg  = PULSE_RESET;
        seen_keys  = '0;
        tap_open   = 1'b0;
        tap_count  = '0;
        period_q   = PERIOD_RESET;
        beat_st    = BEAT_START;
        beat_count = '0;
        step_due   = 1'b0;
        seq_st     = RUN_START;
        step_q     = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table; setup rows wait for the block to go idle.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETUP) begin
                wait_idle();
                apply_setup(directed_rows[i].pat, directed_rows[i].steps,
                            directed_rows[i].pulse);
            end else begin
                push_tick(directed_rows[i].keys, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end
        wait_idle();

        // Random phases: a fresh setting each, then key sequences that look like
        // real use (periodic taps, slow start/stop toggles, held channel keys)
        // with a sprinkle of raw noise ticks.
        lvl      = '0;
        tap_wait = $urandom_range(2, 40);
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != 2);

            pick = $urandom_range(0, 5);
            pat  = (pick == 0) ? '0 : (pick == 1) ? '1 : PAT_W'($urandom);
            pick = $urandom_range(0, 3);
            steps = (pick == 0) ? LEN_W'(1) : (pick == 1) ? LEN_W'(MAX_STEPS)
                                            : LEN_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pulse = '0;
            else if (pick == 1)
                pulse = '1;
            else if (pick == 2)
                pulse = CNT_W'($urandom_range(0, 65535));
            else
                pulse = CNT_W'($urandom_range(1, 30));
            apply_setup(pat, steps, pulse);

            for (n = 0; n < PHASE_TICKS; n++) begin
                if (tap_wait == 0) begin
                    lvl[KEY_TAP] = 1'b1;
                    tap_wait     = $urandom_range(2, 40);
                end else begin
                    lvl[KEY_TAP] = 1'b0;
                    tap_wait--;
                end
                if ($urandom_range(0, 39) == 0) lvl[KEY_RUN] = ~lvl[KEY_RUN];
                for (k = 0; k < KEY_W; k++)
                    if (k != KEY_TAP && k != KEY_RUN && $urandom_range(0, 5) == 0)
                        lvl[k] = ~lvl[k];
                keys = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : lvl;
                push_tick(keys, 1'b0, '0);
            end
            wait_idle();
        end

        // Closing stretch, no idling: longest pulse and a measured tap gap,
        // then a few random ticks back to back.
        idle_on = 1'b0;
        apply_setup(PAT_W'($urandom), LEN_W'(MAX_STEPS), '1);
        if (tap_open) begin
            push_tick(TAP_KEY, 1'b0, '0);
            push_tick('0, 1'b0, '0);
        end
        push_tick(TAP_KEY, 1'b0, '0);
        for (n = 0; n < GAP_TICKS; n++)
            push_tick('0, 1'b0, '0);
        push_tick(TAP_KEY, 1'b0, '0);
        for (n = 0; n < 20; n++)
            push_tick(KEY_W'($urandom_range(0, 63)), 1'b0, '0);
        wait_idle();

        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
